/* hdl/ccrm_pkg.sv */
// Package for the contrast ratio mean block: item types, widths, weights and
// the sRGB linearization table. No dependencies.
package ccrm_pkg;

   localparam int MAX_RUN             = 64;
   localparam int RATIO_FRACTION_BITS = 12;
   localparam int RATIO_INT_BITS      = 5;
   localparam int QUO_BITS            = RATIO_FRACTION_BITS + RATIO_INT_BITS;

   localparam int CH_W    = 8;
   localparam int LIN_W   = 16;
   localparam int PROD_W  = 32;
   localparam int LUM_W   = 33;
   localparam int RATIO_W = 17;
   localparam int SUM_W   = 23;
   localparam int CNT_W   = $clog2(MAX_RUN + 1);
   localparam int STEP_W  = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_BLUE  = 2'd2;

   localparam logic [LIN_W-1:0] W_RED   = 16'd13933;
   localparam logic [LIN_W-1:0] W_GREEN = 16'd46871;
   localparam logic [LIN_W-1:0] W_BLUE  = 16'd4732;
   localparam logic [LUM_W-1:0] LUM_OFFSET = 33'd214748365;

   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [CH_W-1:0]    TEXT_RESET = 8'd255;

   typedef struct packed {
      logic [CH_W-1:0] pixel_red;
      logic [CH_W-1:0] pixel_green;
      logic [CH_W-1:0] pixel_blue;
      logic            last_sample;
   } req_item_type;

   typedef struct packed {
      logic [RATIO_W-1:0] sample_ratio;
      logic [RATIO_W-1:0] mean_ratio;
      logic               mean_valid;
      logic               run_overflow;
   } rsp_item_type;

   typedef struct packed {
      logic [LUM_W-1:0] hi;
      logic [LUM_W-1:0] lo;
      logic             last;
   } lum_pair_type;

   typedef logic [LIN_W-1:0] lin_tab_type [256];

   function automatic lin_tab_type make_lin_tab();
      lin_tab_type t;
      real         v;
      int          y;
      for (int c = 0; c < 256; c++) begin
         if (c <= 10) begin
            y = (1310720 * c + 32946) / 65892;
         end else begin
            v = ((1000.0 * c + 14025.0) / 269025.0) ** 2.4;
            y = $rtoi(65536.0 * v + 0.5);
         end
         if (y > 65535) begin
            y = 65535;
         end
         t[c] = LIN_W'(y);
      end
      return t;
   endfunction

   localparam lin_tab_type LIN_TAB = make_lin_tab();

endpackage

/* hdl/ccrm_front.sv */
// Front part: text color registers, item intake and luminance of both colors.
// Depends on ccrm_pkg; feeds ccrm_fifo.
module ccrm_front import ccrm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_item_type         req_item,
   output logic                 req_full,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CH_W-1:0]      csr_wdata,
   output logic                 pair_push,
   output lum_pair_type         pair,
   input  logic                 pair_full
);

   typedef enum logic [1:0] {S_IDLE, S_MAC, S_PUSH} state_type;

   state_type        state_ff, state_in;
   logic [2:0]       step_ff, step_in;
   req_item_type     item_ff, item_in;
   logic [LUM_W-1:0] lp_ff, lp_in, lt_ff, lt_in;
   logic [CH_W-1:0]  text_red_ff, text_green_ff, text_blue_ff;
   logic [CH_W-1:0]  chan;
   logic [LIN_W-1:0] weight;
   logic [PROD_W-1:0] prod;

   always_comb begin
      unique case (step_ff)
         3'd0:    chan = item_ff.pixel_red;
         3'd1:    chan = item_ff.pixel_green;
         3'd2:    chan = item_ff.pixel_blue;
         3'd3:    chan = text_red_ff;
         3'd4:    chan = text_green_ff;
         default: chan = text_blue_ff;
      endcase
      unique case (step_ff)
         3'd0, 3'd3: weight = W_RED;
         3'd1, 3'd4: weight = W_GREEN;
         default:    weight = W_BLUE;
      endcase
      prod = PROD_W'(LIN_TAB[chan]) * PROD_W'(weight);
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      item_in   = item_ff;
      lp_in     = lp_ff;
      lt_in     = lt_ff;
      pair_push = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_push) begin
               item_in  = req_item;
               lp_in    = LUM_OFFSET;
               lt_in    = LUM_OFFSET;
               step_in  = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            if (step_ff < 3'd3) begin
               lp_in = lp_ff + LUM_W'(prod);
            end else begin
               lt_in = lt_ff + LUM_W'(prod);
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!pair_full) begin
               pair_push = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_full  = (state_ff != S_IDLE);
   assign pair.hi   = (lp_ff > lt_ff) ? lp_ff : lt_ff;
   assign pair.lo   = (lp_ff > lt_ff) ? lt_ff : lp_ff;
   assign pair.last = item_ff.last_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         text_red_ff   <= TEXT_RESET;
         text_green_ff <= TEXT_RESET;
         text_blue_ff  <= TEXT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TEXT_RED:   text_red_ff   <= csr_wdata;
               CSR_TEXT_GREEN: text_green_ff <= csr_wdata;
               CSR_TEXT_BLUE:  text_blue_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
      step_ff <= step_in;
      item_ff <= item_in;
      lp_ff   <= lp_in;
      lt_ff   <= lt_in;
   end

endmodule

/* hdl/ccrm_fifo.sv */
// Two-entry queue of luminance pairs between front and back parts.
// Depends on ccrm_pkg.
module ccrm_fifo import ccrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_push,
   input  lum_pair_type wr_data,
   output logic         wr_full,
   input  logic         rd_pop,
   output lum_pair_type rd_data,
   output logic         rd_empty
);

   lum_pair_type mem [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_wr, do_rd;

   assign wr_full  = (count_ff == 2'd2);
   assign rd_empty = (count_ff == 2'd0);
   assign rd_data  = mem[rd_ptr_ff];
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/ccrm_back.sv */
// Back part: serial divider for ratio and run mean, run accumulation and
// result register. Depends on ccrm_pkg; fed by ccrm_fifo.
module ccrm_back import ccrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   output logic         pair_pop,
   input  lum_pair_type pair,
   input  logic         pair_empty,
   output rsp_item_type rsp_item,
   output logic         rsp_empty,
   input  logic         rsp_pop
);

   typedef enum logic [2:0] {S_IDLE, S_RDIV, S_ACC, S_MSET, S_MDIV, S_DONE} state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [LUM_W-1:0]   rem_ff, rem_in, div_ff, div_in;
   logic [SUM_W-1:0]   num_ff, num_in, quot_ff, quot_in;
   logic               last_ff, last_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_ff, out_in;
   logic [LUM_W:0]     trial;
   logic               fits;
   logic [SUM_W:0]     sum_ext;
   logic               load;

   always_comb begin
      trial   = {rem_ff, num_ff[SUM_W-1]};
      fits    = (trial >= {1'b0, div_ff});
      sum_ext = {1'b0, sum_ff} + (SUM_W + 1)'(ratio_ff);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      last_in  = last_ff;
      ratio_in = ratio_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      out_in   = out_ff;
      pair_pop = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!pair_empty) begin
               pair_pop = 1'b1;
               rem_in   = pair.hi >> RATIO_INT_BITS;
               num_in   = SUM_W'({pair.hi[RATIO_INT_BITS-1:0], {RATIO_FRACTION_BITS{1'b0}}})
                          << (SUM_W - QUO_BITS);
               div_in   = pair.lo;
               last_in  = pair.last;
               quot_in  = '0;
               step_in  = STEP_W'(QUO_BITS);
               state_in = S_RDIV;
            end
         end
         S_RDIV, S_MDIV: begin
            rem_in  = fits ? LUM_W'(trial - {1'b0, div_ff}) : LUM_W'(trial);
            num_in  = {num_ff[SUM_W-2:0], 1'b0};
            quot_in = {quot_ff[SUM_W-2:0], fits};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = (state_ff == S_RDIV) ? S_ACC : S_DONE;
            end
         end
         S_ACC: begin
            ratio_in = (quot_ff > SUM_W'(RATIO_MAX)) ? RATIO_MAX : quot_ff[RATIO_W-1:0];
            state_in = S_MSET;
         end
         S_MSET: begin
            if (count_ff < CNT_W'(MAX_RUN)) begin
               sum_in   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            quot_in  = '0;
            if (last_ff && (count_in != '0)) begin
               rem_in   = '0;
               num_in   = sum_in;
               div_in   = LUM_W'(count_in);
               step_in  = STEP_W'(SUM_W);
               state_in = S_MDIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               load                = 1'b1;
               out_in.sample_ratio = ratio_ff;
               out_in.mean_ratio   = last_ff ? quot_ff[RATIO_W-1:0] : '0;
               out_in.mean_valid   = last_ff;
               out_in.run_overflow = ovf_ff;
               if (last_ff) begin
                  sum_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = (out_valid_ff && !rsp_pop) || load;
   end

   assign rsp_item  = out_ff;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      last_ff  <= last_in;
      ratio_ff <= ratio_in;
      out_ff   <= out_in;
   end

endmodule

/* hdl/color_contrast_ratio_mean.sv */
// Top level of the contrast ratio mean block: front, queue and back parts.
// Depends on ccrm_pkg, ccrm_front, ccrm_fifo and ccrm_back.
//
//   channel   ports                              moves
//   request   req_push, req_full, req_item       one background pixel item
//   response  rsp_pop, rsp_empty, rsp_item       one ratio / mean item
//   csr       csr_we, csr_index, csr_wdata       text color write
//
// Front: one shared multiplier, six table lookups; it takes a new item only
// when idle. Back: a serial divider (one quotient bit per cycle) forms the
// ratio and, on a run's closing item, the run mean; it pops only when idle.
// Reset is synchronous and active high; text color resets to white.
// Front and back stall on their own through a two-entry queue.
module color_contrast_ratio_mean import ccrm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_item_type         req_item,
   output logic                 req_full,
   output rsp_item_type         rsp_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CH_W-1:0]      csr_wdata
);

   lum_pair_type wr_pair, rd_pair;
   logic         wr_push, wr_full, rd_pop, rd_empty;

   ccrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pair_push (wr_push),
      .pair      (wr_pair),
      .pair_full (wr_full)
   );

   ccrm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (wr_push),
      .wr_data  (wr_pair),
      .wr_full  (wr_full),
      .rd_pop   (rd_pop),
      .rd_data  (rd_pair),
      .rd_empty (rd_empty)
   );

   ccrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pair_pop   (rd_pop),
      .pair       (rd_pair),
      .pair_empty (rd_empty),
      .rsp_item   (rsp_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule

/* bench/ccrm_checker.sv */
// Checker for color_contrast_ratio_mean: watches the request, response and csr
// ports, predicts every response item and compares it. Depends on ccrm_pkg.
`timescale 1ns / 100ps

module ccrm_checker import ccrm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  req_item_type         req_item,
   input  logic                 rsp_pop,
   input  logic                 rsp_empty,
   input  rsp_item_type         rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CH_W-1:0]      csr_wdata,
   output int                   errors,
   output int                   pending
);

   typedef logic [383:0] wide_type;

   logic [15:0]    srgb_lin [256];
   logic [7:0]     color_red, color_green, color_blue;
   logic [22:0]    run_sum;
   int             run_count;
   logic           run_over;
   rsp_item_type   expected_items [$];

   function automatic logic [15:0] srgb_entry(int c);
      wide_type bound, probe;
      int       lo, hi, mid;
      if (c <= 10) begin
         return 16'((1310720 * c + 32946) / 65892);
      end
      bound = 1;
      for (int i = 0; i < 12; i++) bound = bound * wide_type'(1000 * c + 14025);
      for (int i = 0; i < 5; i++) bound = bound * wide_type'(131072);
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         probe = 1;
         for (int i = 0; i < 5; i++) probe = probe * wide_type'(2 * mid - 1);
         for (int i = 0; i < 12; i++) probe = probe * wide_type'(269025);
         if (probe <= bound) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return (lo > 65535) ? 16'hFFFF : 16'(lo);
   endfunction

   function automatic logic [63:0] lum_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return 64'(13933) * srgb_lin[r] + 64'(46871) * srgb_lin[g]
           + 64'(4732) * srgb_lin[b] + 64'(214748365);
   endfunction

   function automatic rsp_item_type predict_contrast(req_item_type it);
      rsp_item_type r;
      logic [63:0]  lp, lt, hi, lo, ratio, s;
      lp = lum_of(it.pixel_red, it.pixel_green, it.pixel_blue);
      lt = lum_of(color_red, color_green, color_blue);
      hi = (lp > lt) ? lp : lt;
      lo = (lp > lt) ? lt : lp;
      ratio = (hi << RATIO_FRACTION_BITS) / lo;
      if (ratio > 64'h1FFFF) ratio = 64'h1FFFF;
      if (run_count < MAX_RUN) begin
         s = 64'(run_sum) + ratio;
         run_sum = (s > 64'h7FFFFF) ? 23'h7FFFFF : 23'(s);
         run_count++;
      end else begin
         run_over = 1'b1;
      end
      r.sample_ratio = 17'(ratio);
      r.run_overflow = run_over;
      r.mean_ratio = '0;
      r.mean_valid = 1'b0;
      if (it.last_sample) begin
         if (run_count != 0) r.mean_ratio = 17'(run_sum / run_count);
         r.mean_valid = 1'b1;
         run_sum = '0;
         run_count = 0;
         run_over = 1'b0;
      end
      return r;
   endfunction

   initial begin
      for (int c = 0; c < 256; c++) srgb_lin[c] = srgb_entry(c);
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         color_red = TEXT_RESET;
         color_green = TEXT_RESET;
         color_blue = TEXT_RESET;
         run_sum = '0;
         run_count = 0;
         run_over = 1'b0;
         expected_items.delete();
         errors <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TEXT_RED: begin
                  color_red = csr_wdata;
               end
               CSR_TEXT_GREEN: begin
                  color_green = csr_wdata;
               end
               CSR_TEXT_BLUE: begin
                  color_blue = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_push && !req_full) expected_items.push_back(predict_contrast(req_item));
         if (rsp_pop && !rsp_empty) begin
            if (expected_items.size() == 0) begin
               if (errors < 10) $display("unexpected response item %p", rsp_item);
               errors <= errors + 1;
            end else begin
               want = expected_items.pop_front();
               if (want.sample_ratio !== rsp_item.sample_ratio
                     || want.mean_ratio !== rsp_item.mean_ratio
                     || want.mean_valid !== rsp_item.mean_valid
                     || want.run_overflow !== rsp_item.run_overflow) begin
                  if (errors < 10) begin
                     $display("item mismatch: expected %p, got %p", want, rsp_item);
                  end
                  errors <= errors + 1;
               end
            end
         end
      end
      pending <= expected_items.size();
   end

endmodule

/* bench/color_contrast_ratio_mean_test.sv */
// Testbench top for color_contrast_ratio_mean: clock, reset, stimulus with
// idling and stalls, verdict. Depends on ccrm_pkg and ccrm_checker.
`timescale 1ns / 100ps

module color_contrast_ratio_mean_test;
   import ccrm_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   req_item_type         req_item = '0;
   logic                 req_full;
   rsp_item_type         rsp_item;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TEXT_RED;
   logic [CH_W-1:0]      csr_wdata = '0;
   int                   errors, pending;
   int                   send_idle_pct = 30, recv_idle_pct = 54;
   logic                 stall_armed = 1'b0, stall_done = 1'b0;
   int                   hold_left = 0;

   color_contrast_ratio_mean i_dut (.*);

   ccrm_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_armed && !stall_done) begin
         hold_left <= 400;
         stall_done <= 1'b1;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= '{pixel_red: r, pixel_green: g, pixel_blue: b, last_sample: last};
      do @(posedge clock); while (req_full);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_text(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [7:0]           val [4];
      idx = '{CSR_TEXT_RED, CSR_TEXT_GREEN, CSR_TEXT_BLUE, 2'd3};
      val = '{r, g, b, 8'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_channel();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
      return 8'($urandom);
   endfunction

   initial begin
      int seg_items, run_len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd10, 8'd11, 8'd128, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      drain();
      write_text(8'd0, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
      send_pixel(8'd170, 8'd85, 8'd170, 1'b1);
      drain();
      write_text(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
      drain();
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (seg)
            0: write_text(8'd0, 8'd0, 8'd0);
            3: write_text(8'd255, 8'd255, 8'd255);
            default: write_text(pick_channel(), pick_channel(), pick_channel());
         endcase
         if (seg == 1) stall_armed <= 1'b1;
         seg_items = 0;
         while (seg_items < 140) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 80)
                                               : $urandom_range(1, 30);
            for (int i = 0; i < run_len; i++) begin
               send_pixel(pick_channel(), pick_channel(), pick_channel(), i == run_len - 1);
            end
            seg_items += run_len;
         end
         drain();
      end
      if (errors == 0) begin
         $display("color_contrast_ratio_mean: match");
      end else begin
         $display("color_contrast_ratio_mean: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("color_contrast_ratio_mean: mismatch");
      $finish;
   end

endmodule
